// ----- hw/rtl/compacting_list_store_macros.svh -----
// Assertion macros for the compacting list store.
// Used by the top level; expects clk and rst_n in scope.
`ifndef COMPACTING_LIST_STORE_MACROS_SVH
`define COMPACTING_LIST_STORE_MACROS_SVH

// Plain check that holds at every edge out of reset.
`define CLS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Non-overlapping implication check.
`define CLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/cls_pkg.sv -----
// Shared types and constants for the compacting list store.
// No dependencies.
package cls_pkg;

    localparam int DEPTH    = 64;
    localparam int WIDTH    = 32;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int IN_IDX_W = 6;
    localparam int CMP_W    = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;

    typedef enum logic [1:0] {
        REQ_APPEND   = 2'd0,
        REQ_REMOVE   = 2'd1,
        REQ_CONTAINS = 2'd2,
        REQ_IGNORE   = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic live;
    } cell_ctrl_t;

    typedef struct packed {
        logic append_go;
        logic remove_go;
    } chain_op_t;

endpackage

// ----- hw/rtl/cls_req_if.sv -----
// Request channel of the compacting list store.
// Depends on nothing.
interface cls_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] item_value;
    logic [5:0]  entry_index;

    modport source (output valid, output req_type, output item_value, output entry_index,
                    input ready);
    modport sink   (input valid, input req_type, input item_value, input entry_index,
                    output ready);
endinterface

// ----- hw/rtl/cls_rsp_if.sv -----
// Response channel of the compacting list store.
// Depends on nothing.
interface cls_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ----- hw/rtl/cls_cell.sv -----
// One storage cell of the list chain: holds an entry, loads, shifts, compares.
// Depends on cls_pkg.
module cls_cell
(
    input  logic                     clk,
    input  cls_pkg::cell_ctrl_t      ctrl,
    input  logic [cls_pkg::WIDTH-1:0] key,
    input  logic [cls_pkg::WIDTH-1:0] neighbor_data,
    output logic [cls_pkg::WIDTH-1:0] data,
    output logic                     hit
);

    logic [cls_pkg::WIDTH-1:0] data_reg;
    logic [cls_pkg::WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = neighbor_data;
        end
        else if (ctrl.load)
        begin
            data_next = key;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign hit  = ctrl.live && (data_reg == key);

endmodule

// ----- hw/rtl/cls_chain.sv -----
// Row of list cells with per-position load, shift and live decode.
// Depends on cls_pkg and cls_cell.
module cls_chain
(
    input  logic                      clk,
    input  cls_pkg::chain_op_t        op,
    input  logic [cls_pkg::CMP_W-1:0] idx,
    input  logic [cls_pkg::CNT_W-1:0] count,
    input  logic [cls_pkg::WIDTH-1:0] key,
    output logic [cls_pkg::DEPTH-1:0] hits
);

    logic [cls_pkg::WIDTH-1:0] data_w [cls_pkg::DEPTH];
    logic [cls_pkg::CMP_W-1:0] count_ext;

    assign count_ext = cls_pkg::CMP_W'(count);

    for (genvar i = 0; i < cls_pkg::DEPTH; i++)
    begin : g_cell
        cls_pkg::cell_ctrl_t       ctrl;
        logic [cls_pkg::WIDTH-1:0] nb;

        assign ctrl.live  = cls_pkg::CMP_W'(i) < count_ext;
        assign ctrl.load  = op.append_go && (cls_pkg::CMP_W'(i) == count_ext);
        assign ctrl.shift = op.remove_go && (cls_pkg::CMP_W'(i) >= idx)
                            && (cls_pkg::CMP_W'(i + 1) < count_ext);

        if (i == cls_pkg::DEPTH - 1)
        begin : g_last
            assign nb = data_w[i];
        end
        else
        begin : g_mid
            assign nb = data_w[i + 1];
        end

        cls_cell u_cell
        (
            .clk           (clk),
            .ctrl          (ctrl),
            .key           (key),
            .neighbor_data (nb),
            .data          (data_w[i]),
            .hit           (hits[i])
        );
    end

endmodule

// ----- hw/rtl/compacting_list_store.sv -----
// Top level of the compacting list store: request decode, count, result stages.
// Depends on cls_pkg, cls_req_if, cls_rsp_if, cls_chain and the macros header.
//
//  channel | dir | payload
//  --------+-----+-----------------------------------------
//  req     | in  | req_type, item_value, entry_index
//  rsp     | out | status, entry_count
//
// One request per cycle unless the response stalls. The accepting edge registers
// the per-cell match vector, and advancing the match stage registers the status.
// Reset clears the count and the stage valids; cell contents are not reset.
// A stalled response holds the match stage, which then blocks req.ready.
`include "compacting_list_store_macros.svh"

module compacting_list_store
(
    input  logic         clk,
    input  logic         rst_n,
    cls_req_if.sink      req,
    cls_rsp_if.source    rsp
);

    cls_pkg::req_kind_t        kind;
    logic [cls_pkg::WIDTH-1:0] key;
    logic                      accept;
    logic                      full;
    logic                      idx_ok;
    cls_pkg::chain_op_t        op;
    logic [cls_pkg::DEPTH-1:0] hits;

    logic [cls_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      a_valid_reg;
    cls_pkg::req_kind_t        a_kind_reg;
    cls_pkg::status_t          a_status_reg, a_status_next;
    logic [cls_pkg::CNT_W-1:0] a_count_reg;
    logic [cls_pkg::DEPTH-1:0] a_hits_reg;
    logic                      a_move;
    logic                      out_valid_reg;
    cls_pkg::status_t          out_status_reg, out_status_next;
    logic [cls_pkg::CNT_W-1:0] out_count_reg;
    logic [cls_pkg::CNT_W-1:0] count_inc;
    logic                      stall;

    assign kind   = cls_pkg::req_kind_t'(req.req_type);
    assign key    = cls_pkg::WIDTH'(req.item_value);
    assign a_move = a_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !a_valid_reg || a_move;
    assign accept = req.valid && req.ready;
    assign full   = count_reg == cls_pkg::CNT_W'(cls_pkg::DEPTH);
    assign idx_ok = cls_pkg::CMP_W'(req.entry_index) < cls_pkg::CMP_W'(count_reg);
    assign count_inc = count_reg + 1'b1;
    assign stall  = a_valid_reg && out_valid_reg && !rsp.ready;

    assign op.append_go = accept && (kind == cls_pkg::REQ_APPEND) && !full;
    assign op.remove_go = accept && (kind == cls_pkg::REQ_REMOVE) && idx_ok;

    cls_chain u_chain
    (
        .clk   (clk),
        .op    (op),
        .idx   (cls_pkg::CMP_W'(req.entry_index)),
        .count (count_reg),
        .key   (key),
        .hits  (hits)
    );

    always_comb
    begin
        count_next = count_reg;
        if (op.append_go)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (op.remove_go)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        case (kind)
            cls_pkg::REQ_APPEND: a_status_next = full ? cls_pkg::ST_FULL : cls_pkg::ST_OK;
            cls_pkg::REQ_REMOVE: a_status_next = idx_ok ? cls_pkg::ST_OK : cls_pkg::ST_RANGE;
            default:             a_status_next = cls_pkg::ST_OK;
        endcase
    end

    always_comb
    begin
        out_status_next = a_status_reg;
        if (a_kind_reg == cls_pkg::REQ_CONTAINS)
        begin
            out_status_next = (|a_hits_reg) ? cls_pkg::ST_OK : cls_pkg::ST_NOTFOUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_kind_reg   <= kind;
            a_status_reg <= a_status_next;
            a_count_reg  <= count_next;
            a_hits_reg   <= hits;
        end
        if (a_move)
        begin
            out_status_reg <= out_status_next;
            out_count_reg  <= a_count_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_count = 7'(out_count_reg);

    `CLS_ASSERT(a_count_bound, count_reg <= cls_pkg::CNT_W'(cls_pkg::DEPTH), "count exceeds depth")
    `CLS_ASSERT_NEXT(a_append_grows, op.append_go, count_reg == $past(count_inc), "append lost")
    `CLS_ASSERT_NEXT(a_stage_hold, stall, a_valid_reg && $stable(a_hits_reg), "stage lost")

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for compacting_list_store: append, remove and membership requests.
// Checks every response in order against a list model kept in the bench.
// Depends on cls_pkg, cls_req_if, cls_rsp_if and the compacting_list_store RTL.
module tb_top;

    typedef struct packed {
        cls_pkg::req_kind_t kind;
        logic [31:0]        value;
        logic [5:0]         index;
    } list_req_t;

    typedef struct packed {
        cls_pkg::status_t status;
        logic [6:0]       count;
    } list_rsp_t;

    localparam int RANDOM_REQS = 1800;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;

    cls_req_if req_ch ();
    cls_rsp_if rsp_ch ();

    compacting_list_store dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #2 clk = ~clk;

    list_req_t                 pending_reqs[$];
    list_rsp_t                 expected_rsps[$];
    logic [cls_pkg::WIDTH-1:0] list_slots[cls_pkg::DEPTH];
    int                        list_len = 0;
    int                        gen_len = 0;
    logic [31:0]               value_pool[8];

    int  n_total = 0;
    int  n_acc = 0;
    int  errors = 0;
    bit  req_taken = 1'b0;
    bit  hold_off = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;

    function automatic list_rsp_t list_apply(list_req_t r);
        list_rsp_t res;
        int        k;
        res.status = cls_pkg::ST_OK;
        case (r.kind)
            cls_pkg::REQ_APPEND:
            begin
                if (list_len >= cls_pkg::DEPTH)
                    res.status = cls_pkg::ST_FULL;
                else
                begin
                    list_slots[list_len] = r.value[cls_pkg::WIDTH-1:0];
                    list_len++;
                end
            end
            cls_pkg::REQ_REMOVE:
            begin
                if (int'(r.index) >= list_len)
                    res.status = cls_pkg::ST_RANGE;
                else
                begin
                    for (k = int'(r.index); k < list_len - 1; k++)
                        list_slots[k] = list_slots[k + 1];
                    list_len--;
                end
            end
            cls_pkg::REQ_CONTAINS:
            begin
                res.status = cls_pkg::ST_NOTFOUND;
                for (k = 0; k < list_len; k++)
                    if (list_slots[k] == r.value[cls_pkg::WIDTH-1:0])
                        res.status = cls_pkg::ST_OK;
            end
            default:
            begin
            end
        endcase
        res.count = list_len[6:0];
        return res;
    endfunction

    task automatic add_req(cls_pkg::req_kind_t kind, logic [31:0] value, logic [5:0] index);
        list_req_t r;
        r.kind  = kind;
        r.value = value;
        r.index = index;
        pending_reqs.push_back(r);
        if (kind == cls_pkg::REQ_APPEND && gen_len < cls_pkg::DEPTH)
            gen_len++;
        else if (kind == cls_pkg::REQ_REMOVE && int'(index) < gen_len)
            gen_len--;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 99) < 60)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [5:0] pick_index();
        if (gen_len > 0 && $urandom_range(0, 99) < 85)
            return 6'($urandom_range(0, gen_len - 1));
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic bit idling_allowed();
        if (n_acc >= n_total - 150)
            return 1'b0;
        return ((n_acc / 150) % 3) != 2;
    endfunction

    // stimulus and end of run
    initial
    begin
        int useful;
        int mode;
        int phase_left;
        int roll;
        int append_pct;
        int remove_pct;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = cls_pkg::REQ_APPEND;
        req_ch.item_value = '0;
        req_ch.entry_index = '0;
        rsp_ch.ready = 1'b0;

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            value_pool[i] = $urandom;

        // directed: empty list, field extremes, shifting, duplicates, unused kind
        add_req(cls_pkg::REQ_CONTAINS, 32'h0, 6'd0);
        add_req(cls_pkg::REQ_REMOVE, 32'h0, 6'd0);
        add_req(cls_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 6'd63);
        add_req(cls_pkg::REQ_IGNORE, 32'h0, 6'd0);
        add_req(cls_pkg::REQ_APPEND, 32'h0, 6'd0);
        add_req(cls_pkg::REQ_APPEND, 32'hFFFF_FFFF, 6'd63);
        add_req(cls_pkg::REQ_APPEND, 32'h5555_5555, 6'd0);
        add_req(cls_pkg::REQ_APPEND, 32'hAAAA_AAAA, 6'd0);
        add_req(cls_pkg::REQ_CONTAINS, 32'hFFFF_FFFF, 6'd0);
        add_req(cls_pkg::REQ_CONTAINS, 32'h0, 6'd0);
        add_req(cls_pkg::REQ_CONTAINS, 32'h0000_1234, 6'd0);
        add_req(cls_pkg::REQ_REMOVE, 32'h0, 6'd4);
        add_req(cls_pkg::REQ_REMOVE, 32'h0, 6'd3);
        add_req(cls_pkg::REQ_REMOVE, 32'h0, 6'd0);
        add_req(cls_pkg::REQ_CONTAINS, 32'h0, 6'd0);
        add_req(cls_pkg::REQ_CONTAINS, 32'hAAAA_AAAA, 6'd0);
        add_req(cls_pkg::REQ_IGNORE, 32'hFFFF_FFFF, 6'd63);
        add_req(cls_pkg::REQ_APPEND, 32'h0000_0007, 6'd0);
        add_req(cls_pkg::REQ_APPEND, 32'h0000_0007, 6'd0);
        add_req(cls_pkg::REQ_REMOVE, 32'h0, 6'd2);
        add_req(cls_pkg::REQ_CONTAINS, 32'h0000_0007, 6'd0);
        add_req(cls_pkg::REQ_CONTAINS, 32'h5555_5555, 6'd0);

        // random phases: fill, drain, mixed
        useful = 0;
        mode = 0;
        phase_left = 120;
        while (useful < RANDOM_REQS)
        begin
            if (phase_left == 0)
            begin
                mode = $urandom_range(0, 2);
                phase_left = $urandom_range(60, 150);
            end
            phase_left--;
            if ($urandom_range(0, 99) < 3)
                add_req(cls_pkg::REQ_IGNORE, $urandom, 6'($urandom_range(0, 63)));
            else
            begin
                useful++;
                append_pct = (mode == 0) ? 80 : (mode == 1) ? 10 : 40;
                remove_pct = (mode == 0) ? 10 : (mode == 1) ? 75 : 30;
                roll = $urandom_range(0, 99);
                if (roll < append_pct)
                    add_req(cls_pkg::REQ_APPEND, pick_value(), 6'($urandom_range(0, 63)));
                else if (roll < append_pct + remove_pct)
                    add_req(cls_pkg::REQ_REMOVE, $urandom, pick_index());
                else
                    add_req(cls_pkg::REQ_CONTAINS, pick_value(), 6'($urandom_range(0, 63)));
            end
        end
        n_total = pending_reqs.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (n_acc < n_total)
            @(posedge clk);
        while (expected_rsps.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

    // long response stall so the pipeline backs up into the request side
    initial
    begin
        while (n_acc < 400)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // request driver
    always @(negedge clk)
    begin
        list_req_t nxt;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (idling_allowed() && !hold_off && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 9);
                req_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                nxt = pending_reqs.pop_front();
                req_ch.req_type <= nxt.kind;
                req_ch.item_value <= nxt.value;
                req_ch.entry_index <= nxt.index;
                req_ch.valid <= 1'b1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // response ready
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_off)
            rsp_ch.ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
        end
        else if (idling_allowed() && $urandom_range(0, 7) == 0)
        begin
            recv_gap = $urandom_range(0, 9);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // monitor: check responses, predict accepted requests
    always @(posedge clk)
    begin
        list_req_t acc;
        list_rsp_t want;
        req_taken = 1'b0;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected response: status=%0d count=%0d",
                                 rsp_ch.status, rsp_ch.entry_count);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.entry_count !== want.count)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"response mismatch: status exp=%0d got=%0d,",
                                      " count exp=%0d got=%0d"},
                                     want.status, rsp_ch.status, want.count,
                                     rsp_ch.entry_count);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                req_taken = 1'b1;
                acc.kind = cls_pkg::req_kind_t'(req_ch.req_type);
                acc.value = req_ch.item_value;
                acc.index = req_ch.entry_index;
                expected_rsps.push_back(list_apply(acc));
                n_acc++;
            end
        end
    end

endmodule
